/* sv/fqs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and ring arithmetic for the FIFO queue with search.
// No dependencies.
package fqs_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = 5;
  localparam int DW    = 32;
  localparam int CMPW  = (CW > PW) ? CW : PW;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_READ = 2'd2,
    OP_SRCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // wrap head plus offset back into the ring; offset never exceeds DEPTH
  function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(off);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

/* sv/fifo_queue_with_search_core.sv */
`timescale 1ns / 1ps
// FIFO queue with search: ring control, sequencer and result register around fqs_ram.
// Depends on fqs_pkg and fqs_ram.
// Enqueue and dequeue/read misses answer from the execute state; dequeue and read hits
// wait in a read-wait state for the registered RAM data; search scans from the head to
// the first hit or the fill count. One item at a time; search reads one entry per cycle
// while the output is free. Reset clears pointers, sequencer, result valid, not memory.
module fifo_queue_with_search_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               op_i,
  input  logic signed [31:0]       item_value_i,
  input  logic [4:0]               position_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [31:0]       data_out_o,
  output logic [4:0]               position_out_o
);

  localparam int AW = fqs_pkg::AW;
  localparam int CW = fqs_pkg::CW;
  localparam int PW = fqs_pkg::PW;
  localparam int DW = fqs_pkg::DW;
  localparam int CMPW = fqs_pkg::CMPW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN
  } state_e;

  state_e               state_q, state_d;
  fqs_pkg::op_e         op_q, op_d;
  logic [DW-1:0]        value_q, value_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        scan_idx_q, scan_idx_d;
  logic [CW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                 cmp_valid_q, cmp_valid_d;
  logic                 out_valid_q, out_valid_d;
  fqs_pkg::status_e     status_q, status_d;
  logic [DW-1:0]        data_q, data_d;
  logic [PW-1:0]        where_q, where_d;

  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [DW-1:0]        mem_rdata;
  logic                 out_free;
  logic                 full;
  logic                 empty;

  fqs_ram #(
    .Depth (fqs_pkg::DEPTH),
    .Width (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (value_q),
    .rdata_o (mem_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (count_q == CW'(fqs_pkg::DEPTH));
  assign empty    = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    value_d     = value_q;
    pos_d       = pos_q;
    head_d      = head_q;
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_valid_d = cmp_valid_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    data_d      = data_q;
    where_d     = where_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = fqs_pkg::op_e'(op_i);
          value_d = item_value_i;
          pos_d   = position_in_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          unique case (op_q)
            fqs_pkg::OP_ENQ: begin
              out_valid_d = 1'b1;
              data_d      = '0;
              state_d     = S_IDLE;
              if (full) begin
                status_d = fqs_pkg::ST_FULL;
                where_d  = '0;
              end else begin
                mem_we   = 1'b1;
                mem_addr = fqs_pkg::ring_idx(head_q, count_q);
                count_d  = count_q + CW'(1);
                status_d = fqs_pkg::ST_OK;
                where_d  = PW'(count_q);
              end
            end
            fqs_pkg::OP_DEQ: begin
              if (empty) begin
                out_valid_d = 1'b1;
                status_d    = fqs_pkg::ST_MISS;
                data_d      = '0;
                where_d     = '0;
                state_d     = S_IDLE;
              end else begin
                mem_re   = 1'b1;
                mem_addr = head_q;
                head_d   = fqs_pkg::ring_idx(head_q, CW'(1));
                count_d  = count_q - CW'(1);
                state_d  = S_RDWAIT;
              end
            end
            fqs_pkg::OP_READ: begin
              if (CMPW'(pos_q) >= CMPW'(count_q)) begin
                out_valid_d = 1'b1;
                status_d    = fqs_pkg::ST_MISS;
                data_d      = '0;
                where_d     = '0;
                state_d     = S_IDLE;
              end else begin
                mem_re   = 1'b1;
                mem_addr = fqs_pkg::ring_idx(head_q, CW'(pos_q));
                state_d  = S_RDWAIT;
              end
            end
            fqs_pkg::OP_SRCH: begin
              scan_idx_d  = '0;
              cmp_valid_d = 1'b0;
              state_d     = S_SCAN;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = fqs_pkg::ST_OK;
          data_d      = mem_rdata;
          where_d     = '0;
          state_d     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (cmp_valid_q && (mem_rdata == value_q)) begin
            out_valid_d = 1'b1;
            status_d    = fqs_pkg::ST_OK;
            data_d      = '0;
            where_d     = PW'(cmp_idx_q);
            state_d     = S_IDLE;
          end else if (scan_idx_q >= count_q) begin
            out_valid_d = 1'b1;
            status_d    = fqs_pkg::ST_MISS;
            data_d      = '0;
            where_d     = '0;
            state_d     = S_IDLE;
          end else begin
            mem_re      = 1'b1;
            mem_addr    = fqs_pkg::ring_idx(head_q, scan_idx_q);
            cmp_valid_d = 1'b1;
            cmp_idx_d   = scan_idx_q;
            scan_idx_d  = scan_idx_q + CW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= fqs_pkg::OP_ENQ;
      value_q     <= '0;
      pos_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      cmp_idx_q   <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= fqs_pkg::ST_OK;
      data_q      <= '0;
      where_q     <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      value_q     <= value_d;
      pos_q       <= pos_d;
      head_q      <= head_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      data_q      <= data_d;
      where_q     <= where_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign data_out_o     = data_q;
  assign position_out_o = where_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(fqs_pkg::DEPTH))
    else $error("fill count above capacity");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !full)
    else $error("memory write while full");

  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> count_q == $past(count_q) + CW'(1))
    else $error("fill count did not advance on enqueue");

  a_read_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> (state_q == S_RDWAIT || state_q == S_SCAN))
    else $error("read data issued with nobody to consume it");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> scan_idx_q <= count_q)
    else $error("search ran past the fill count");

endmodule

/* sv/fqs_ram.sv */
`timescale 1ns / 1ps
// Single-port synchronous RAM with registered read data.
// No dependencies.
module fqs_ram #(
  parameter int Depth = 32,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/tb_fifo_queue_with_search_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fifo_queue_with_search_core: directed and random operations
// with bursty input and a stalling receiver, each result checked against a queue model.
// Depends on fqs_pkg and the core with its memory.
module tb_fifo_queue_with_search_core;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_WAIT  = 2 * fqs_pkg::DEPTH + 8;

  typedef struct packed {
    fqs_pkg::status_e              status;
    logic signed [fqs_pkg::DW-1:0] data;
    logic [fqs_pkg::PW-1:0]        pos;
  } queue_result_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    op_i           = fqs_pkg::OP_ENQ;
  logic signed [fqs_pkg::DW-1:0] item_value_i   = '0;
  logic [fqs_pkg::PW-1:0]        position_in_i  = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic [1:0]                    status_o;
  logic signed [fqs_pkg::DW-1:0] data_out_o;
  logic [fqs_pkg::PW-1:0]        position_out_o;

  logic signed [fqs_pkg::DW-1:0] q_mem [fqs_pkg::DEPTH];
  int unsigned                   q_head  = 0;
  int unsigned                   q_count = 0;
  queue_result_t                 pending_results [$];

  int unsigned           mismatch_cnt = 0;
  int unsigned           cycle_cnt    = 0;
  int unsigned           burst_left   = 0;
  int unsigned           rdy_left     = 0;
  int unsigned           rdy_mode     = 0;

  fifo_queue_with_search_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .item_value_i   (item_value_i),
    .position_in_i  (position_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .position_out_o (position_out_o)
  );

  always #5ns clk_i = ~clk_i;

  function automatic queue_result_t apply_queue_op(fqs_pkg::op_e op,
                                                   logic signed [fqs_pkg::DW-1:0] val,
                                                   logic [fqs_pkg::PW-1:0] pos);
    queue_result_t res;
    res = '{status: fqs_pkg::ST_OK, data: '0, pos: '0};
    case (op)
      fqs_pkg::OP_ENQ: begin
        if (q_count >= fqs_pkg::DEPTH) begin
          res.status = fqs_pkg::ST_FULL;
        end else begin
          q_mem[(q_head + q_count) % fqs_pkg::DEPTH] = val;
          res.pos = fqs_pkg::PW'(q_count);
          q_count++;
        end
      end
      fqs_pkg::OP_DEQ: begin
        if (q_count == 0) begin
          res.status = fqs_pkg::ST_MISS;
        end else begin
          res.data = q_mem[q_head];
          q_head = (q_head + 1) % fqs_pkg::DEPTH;
          q_count--;
        end
      end
      fqs_pkg::OP_READ: begin
        if (pos >= q_count) begin
          res.status = fqs_pkg::ST_MISS;
        end else begin
          res.data = q_mem[(q_head + pos) % fqs_pkg::DEPTH];
        end
      end
      default: begin
        res.status = fqs_pkg::ST_MISS;
        for (int unsigned i = 0; i < q_count; i++) begin
          if (q_mem[(q_head + i) % fqs_pkg::DEPTH] == val) begin
            res.status = fqs_pkg::ST_OK;
            res.pos = fqs_pkg::PW'(i);
            break;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic send_item(fqs_pkg::op_e op, logic signed [fqs_pkg::DW-1:0] val,
                           logic [fqs_pkg::PW-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    item_value_i  <= val;
    position_in_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    pending_results.push_back(apply_queue_op(op, val, pos));
  endtask

  function automatic logic signed [fqs_pkg::DW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return fqs_pkg::DW'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int unsigned w_enq, int unsigned w_deq, int unsigned w_read,
                             int unsigned w_srch);
    int unsigned                   pick;
    fqs_pkg::op_e                  op;
    logic signed [fqs_pkg::DW-1:0] val;
    logic [fqs_pkg::PW-1:0]        pos;
    pick = $urandom_range(0, w_enq + w_deq + w_read + w_srch - 1);
    if (pick < w_enq) begin
      op = fqs_pkg::OP_ENQ;
    end else if (pick < w_enq + w_deq) begin
      op = fqs_pkg::OP_DEQ;
    end else if (pick < w_enq + w_deq + w_read) begin
      op = fqs_pkg::OP_READ;
    end else begin
      op = fqs_pkg::OP_SRCH;
    end
    val = pick_value();
    pos = fqs_pkg::PW'($urandom_range(0, 31));
    if (op == fqs_pkg::OP_SRCH && q_count > 0 && $urandom_range(0, 2) != 0) begin
      val = q_mem[(q_head + $urandom_range(0, q_count - 1)) % fqs_pkg::DEPTH];
    end
    if (op == fqs_pkg::OP_READ && q_count > 0 && $urandom_range(0, 4) < 3) begin
      pos = fqs_pkg::PW'($urandom_range(0, q_count - 1));
    end
    send_item(op, val, pos);
  endtask

  task automatic test_directed_edges();
    send_item(fqs_pkg::OP_DEQ,  32'h0000_0000, 5'd0);
    send_item(fqs_pkg::OP_READ, 32'h0000_0000, 5'd0);
    send_item(fqs_pkg::OP_READ, 32'hffff_ffff, 5'd31);
    send_item(fqs_pkg::OP_SRCH, 32'h0000_0000, 5'd0);
    send_item(fqs_pkg::OP_SRCH, 32'h8000_0000, 5'd31);
    send_item(fqs_pkg::OP_ENQ,  32'h8000_0000, 5'd31);
    send_item(fqs_pkg::OP_ENQ,  32'h7fff_ffff, 5'd0);
    send_item(fqs_pkg::OP_ENQ,  32'h0000_0000, 5'd0);
    send_item(fqs_pkg::OP_ENQ,  32'hffff_ffff, 5'd0);
    send_item(fqs_pkg::OP_ENQ,  32'h8000_0000, 5'd0);
    send_item(fqs_pkg::OP_READ, 32'h0000_0000, 5'd0);
    send_item(fqs_pkg::OP_READ, 32'h0000_0000, 5'd4);
    send_item(fqs_pkg::OP_READ, 32'h0000_0000, 5'd5);
    send_item(fqs_pkg::OP_READ, 32'h0000_0000, 5'd31);
    send_item(fqs_pkg::OP_SRCH, 32'h8000_0000, 5'd0);
    send_item(fqs_pkg::OP_SRCH, 32'hffff_ffff, 5'd0);
    send_item(fqs_pkg::OP_SRCH, 32'h0000_3039, 5'd0);
    send_item(fqs_pkg::OP_DEQ,  32'h0000_0000, 5'd0);
    send_item(fqs_pkg::OP_DEQ,  32'h0000_0000, 5'd0);
    send_item(fqs_pkg::OP_READ, 32'h0000_0000, 5'd0);
    send_item(fqs_pkg::OP_SRCH, 32'h8000_0000, 5'd0);
    send_item(fqs_pkg::OP_SRCH, 32'h7fff_ffff, 5'd0);
  endtask

  task automatic test_fill_drain();
    repeat (4) begin
      while (q_count < fqs_pkg::DEPTH) send_random(8, 1, 1, 1);
      repeat ($urandom_range(3, 8)) send_random(3, 0, 2, 2);
      while (q_count > 0) send_random(1, 8, 1, 1);
      repeat ($urandom_range(3, 8)) send_random(0, 3, 2, 2);
    end
  endtask

  task automatic test_random_mix();
    repeat (800) begin
      if (q_count < 4) begin
        send_random(4, 1, 2, 2);
      end else if (q_count > fqs_pkg::DEPTH - 4) begin
        send_random(1, 4, 2, 2);
      end else begin
        send_random(2, 2, 2, 2);
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 2);
      rdy_left <= $urandom_range(20, 300);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 2) == 0);
      default: out_ready_i <= (cycle_cnt[3:0] < 4'd5);
    endcase
  end

  always @(posedge clk_i) begin
    queue_result_t res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("%0t: unexpected result status=%0d data=%0d pos=%0d", $realtime,
                   status_o, data_out_o, position_out_o);
        end
      end else begin
        res = pending_results.pop_front();
        if (status_o !== res.status || data_out_o !== res.data
            || position_out_o !== res.pos) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: expected status=%0d data=%0d pos=%0d, got status=%0d data=%0d pos=%0d",
                     $realtime, res.status, res.data, res.pos, status_o, data_out_o,
                     position_out_o);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_fill_drain();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
